>>> rtl/core/lfsgd_pkg.sv
// Package: shared constants, op codes and controller/datapath command types.
`default_nettype none
package lfsgd_pkg;
    localparam int NumFeaturesDef = 50;
    localparam int UserRowsDef    = 65536;
    localparam int MovieRowsDef   = 32768;

    localparam logic [15:0] LearnRateRst = 16'd328;
    localparam logic [15:0] RegWeightRst = 16'd1638;

    localparam logic [0:0] CfgLearnRate = 1'b0;
    localparam logic [0:0] CfgRegWeight = 1'b1;

    localparam logic [1:0] OpPredict   = 2'd0;
    localparam logic [1:0] OpTrain     = 2'd1;
    localparam logic [1:0] OpWriteUser = 2'd2;
    localparam logic [1:0] OpWriteMov  = 2'd3;

    // datapath step selected by the controller
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RD,
        CMD_MAC,
        CMD_ERR,
        CMD_PROD,
        CMD_SCALE,
        CMD_WRITE
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic clr;
    } ctrl_t;

    typedef struct packed {
        logic last_feat;
        logic wr_op;
    } stat_t;
endpackage
`default_nettype wire

>>> rtl/core/lfsgd_datapath.sv
// Datapath: factor memories, multipliers, accumulator and update logic.
`default_nettype none
module lfsgd_datapath #(
    parameter int NUM_FEATURES = lfsgd_pkg::NumFeaturesDef,
    parameter int USER_ROWS    = lfsgd_pkg::UserRowsDef,
    parameter int MOVIE_ROWS   = lfsgd_pkg::MovieRowsDef
) (
    input  wire                 aclk,
    input  wire lfsgd_pkg::ctrl_t ctrl,
    output lfsgd_pkg::stat_t    stat,
    input  wire [1:0]           in_op,
    input  wire [15:0]          in_user_row,
    input  wire [14:0]          in_movie_row,
    input  wire [5:0]           in_feature,
    input  wire signed [31:0]   in_value,
    input  wire [15:0]          learn_rate,
    input  wire [15:0]          reg_weight,
    output logic signed [31:0]  res_value,
    output logic                res_sat
);
    localparam int FW  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int UW  = (USER_ROWS > 1) ? $clog2(USER_ROWS) : 1;
    localparam int MW  = (MOVIE_ROWS > 1) ? $clog2(MOVIE_ROWS) : 1;
    localparam int UDW = $clog2(USER_ROWS * NUM_FEATURES);
    localparam int MDW = $clog2(MOVIE_ROWS * NUM_FEATURES);
    localparam int AW  = 48 + FW + 1;
    localparam logic [FW-1:0] LastF = FW'(NUM_FEATURES - 1);

    // row reduction: a mask for power-of-two depths, else a reciprocal multiply
    localparam bit UPow2 = ((USER_ROWS & (USER_ROWS - 1)) == 0);
    localparam bit MPow2 = ((MOVIE_ROWS & (MOVIE_ROWS - 1)) == 0);
    localparam logic [31:0] URecip = 32'((64'd1 << 32) / 64'(USER_ROWS));
    localparam logic [31:0] MRecip = 32'((64'd1 << 32) / 64'(MOVIE_ROWS));

    logic signed [31:0] umem [USER_ROWS*NUM_FEATURES];
    logic signed [31:0] mmem [MOVIE_ROWS*NUM_FEATURES];

    logic [1:0]         op_reg;
    logic [UW-1:0]      urow_reg;
    logic [MW-1:0]      mrow_reg;
    logic [5:0]         feat_reg;
    logic signed [31:0] val_reg;
    logic [FW-1:0]      idx_reg;
    logic signed [31:0] u_reg, m_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [31:0] err_reg;
    logic               sat_reg;
    // update pipeline
    logic signed [48:0] du_reg, dm_reg;
    logic signed [31:0] nu_reg, nm_reg;

    logic [UDW-1:0] uaddr;
    logic [MDW-1:0] maddr;
    logic [FW-1:0]  aidx;
    logic [UW-1:0]  urow_mod;
    logic [MW-1:0]  mrow_mod;

    // row reduced modulo table depth
    if (UPow2) begin : g_urow_mask
        assign urow_mod = UW'(in_user_row);
    end else begin : g_urow_recip
        logic [47:0] q_prod;
        logic [36:0] r_est;
        always_comb begin
            q_prod   = in_user_row * URecip;
            r_est    = 37'(in_user_row) - 37'(q_prod[47:32]) * 37'(USER_ROWS);
            urow_mod = (r_est >= 37'(USER_ROWS)) ? UW'(r_est - 37'(USER_ROWS))
                                                 : UW'(r_est);
        end
    end

    if (MPow2) begin : g_mrow_mask
        assign mrow_mod = MW'(in_movie_row);
    end else begin : g_mrow_recip
        logic [47:0] q_prod;
        logic [36:0] r_est;
        always_comb begin
            q_prod   = in_movie_row * MRecip;
            r_est    = 37'(in_movie_row) - 37'(q_prod[47:32]) * 37'(MOVIE_ROWS);
            mrow_mod = (r_est >= 37'(MOVIE_ROWS)) ? MW'(r_est - 37'(MOVIE_ROWS))
                                                  : MW'(r_est);
        end
    end

    always_comb begin
        aidx  = (op_reg[1]) ? FW'(feat_reg) : idx_reg;
        uaddr = UDW'(urow_reg * NUM_FEATURES) + UDW'(aidx);
        maddr = MDW'(mrow_reg * NUM_FEATURES) + MDW'(aidx);
    end

    function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v,
                                                 output logic f);
        logic signed [AW-1:0] mx, mn;
        mx = AW'(64'sh7FFFFFFF);
        mn = -mx - 1;
        f = 1'b0;
        if (v > mx) begin
            f = 1'b1; return 32'sh7FFFFFFF;
        end else if (v < mn) begin
            f = 1'b1; return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    logic signed [63:0] p_uv;
    logic signed [63:0] p_em, p_eu;
    logic signed [48:0] p_ru, p_rm;
    logic signed [65:0] p_lu, p_lm;
    logic signed [AW-1:0] acc_n;
    logic signed [AW-1:0] err_w, nu_w, nm_w;
    logic signed [31:0] sat_dot, sat_err, sat_nu, sat_nm;
    logic f0, f1, f2, f3;

    always_comb begin
        p_uv = u_reg * m_reg;
        p_em = err_reg * m_reg;
        p_eu = err_reg * u_reg;
        p_ru = $signed({1'b0, reg_weight}) * u_reg;
        p_rm = $signed({1'b0, reg_weight}) * m_reg;
        p_lu = $signed({1'b0, learn_rate}) * du_reg;
        p_lm = $signed({1'b0, learn_rate}) * dm_reg;
        acc_n = acc_reg + AW'(p_uv >>> 16);
        sat_dot = sat32(acc_reg, f0);
        err_w = AW'(val_reg) - AW'(sat_dot);
        sat_err = sat32(err_w, f1);
        nu_w = AW'(u_reg) + AW'(p_lu >>> 16);
        nm_w = AW'(m_reg) + AW'(p_lm >>> 16);
        sat_nu = sat32(nu_w, f2);
        sat_nm = sat32(nm_w, f3);
    end

    always_comb begin
        stat.last_feat = (idx_reg == LastF);
        stat.wr_op     = op_reg[1];
        res_value      = err_reg;
        res_sat        = sat_reg;
    end

    always_ff @(posedge aclk) begin
        case (ctrl.cmd)
            lfsgd_pkg::CMD_LOAD: begin
                op_reg   <= in_op;
                urow_reg <= urow_mod;
                mrow_reg <= mrow_mod;
                feat_reg <= in_feature;
                val_reg  <= in_value;
                idx_reg  <= '0;
                acc_reg  <= '0;
                sat_reg  <= 1'b0;
                err_reg  <= '0;
            end
            lfsgd_pkg::CMD_RD: begin
                u_reg <= umem[uaddr];
                m_reg <= mmem[maddr];
            end
            lfsgd_pkg::CMD_MAC: begin
                acc_reg <= acc_n;
                if (ctrl.clr) begin
                    idx_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            lfsgd_pkg::CMD_ERR: begin
                sat_reg <= f0 | ((op_reg == lfsgd_pkg::OpTrain) & f1);
                err_reg <= (op_reg == lfsgd_pkg::OpTrain) ? sat_err : sat_dot;
            end
            lfsgd_pkg::CMD_PROD: begin
                du_reg <= 49'(p_em >>> 16) - 49'(p_ru >>> 16);
                dm_reg <= 49'(p_eu >>> 16) - 49'(p_rm >>> 16);
            end
            lfsgd_pkg::CMD_SCALE: begin
                nu_reg  <= sat_nu;
                nm_reg  <= sat_nm;
                sat_reg <= sat_reg | f2 | f3;
            end
            lfsgd_pkg::CMD_WRITE: begin
                if (op_reg[1]) begin
                    if (9'(feat_reg) < 9'(NUM_FEATURES)) begin
                        if (op_reg == lfsgd_pkg::OpWriteUser) begin
                            umem[uaddr] <= val_reg;
                        end else begin
                            mmem[maddr] <= val_reg;
                        end
                    end
                end else begin
                    umem[uaddr] <= nu_reg;
                    mmem[maddr] <= nm_reg;
                    idx_reg     <= idx_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/core/lfsgd_ctrl.sv
// Controller: sequences predict, train and write items over the datapath.
`default_nettype none
module lfsgd_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  wire [1:0]        s_op,
    output logic             m_valid,
    input  wire              m_ready,
    input  wire lfsgd_pkg::stat_t stat,
    output lfsgd_pkg::ctrl_t ctrl
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_MAC, ST_ERR, ST_URD, ST_PROD, ST_SCALE, ST_WR, ST_WOP, ST_OUT
    } state_t;

    state_t state_reg;
    logic   train_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);

    always_comb begin
        ctrl.clr = 1'b0;
        case (state_reg)
            ST_IDLE:  ctrl.cmd = s_valid ? lfsgd_pkg::CMD_LOAD : lfsgd_pkg::CMD_NONE;
            ST_RD:    ctrl.cmd = lfsgd_pkg::CMD_RD;
            ST_URD:   ctrl.cmd = lfsgd_pkg::CMD_RD;
            ST_MAC: begin
                ctrl.cmd = lfsgd_pkg::CMD_MAC;
                ctrl.clr = stat.last_feat;
            end
            ST_ERR:   ctrl.cmd = lfsgd_pkg::CMD_ERR;
            ST_PROD:  ctrl.cmd = lfsgd_pkg::CMD_PROD;
            ST_SCALE: ctrl.cmd = lfsgd_pkg::CMD_SCALE;
            ST_WR:    ctrl.cmd = lfsgd_pkg::CMD_WRITE;
            ST_WOP:   ctrl.cmd = lfsgd_pkg::CMD_WRITE;
            default:  ctrl.cmd = lfsgd_pkg::CMD_NONE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            train_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: if (s_valid) begin
                    train_reg <= (s_op == lfsgd_pkg::OpTrain);
                    state_reg <= s_op[1] ? ST_WOP : ST_RD;
                end
                ST_WOP:  state_reg <= ST_OUT;
                ST_RD:   state_reg <= ST_MAC;
                ST_MAC:  state_reg <= stat.last_feat ? ST_ERR : ST_RD;
                ST_ERR:  state_reg <= train_reg ? ST_URD : ST_OUT;
                ST_URD:  state_reg <= ST_PROD;
                ST_PROD: state_reg <= ST_SCALE;
                ST_SCALE: state_reg <= ST_WR;
                ST_WR:   state_reg <= stat.last_feat ? ST_OUT : ST_URD;
                ST_OUT:  if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/latent_factor_sgd_update_core.sv
// Latent factor SGD update core: top level with configuration registers.
// Predict runs K read/MAC pairs; train adds K four-step read-modify-write
// updates of both factor rows; a feature write needs no reads. A new item
// is taken only after the previous result has been accepted.
// Reset (synchronous, active low) clears control and restores learn_rate
// and reg_weight; factor memories are not cleared.
`default_nettype none
module latent_factor_sgd_update_core #(
    parameter int NUM_FEATURES = lfsgd_pkg::NumFeaturesDef,
    parameter int USER_ROWS    = lfsgd_pkg::UserRowsDef,
    parameter int MOVIE_ROWS   = lfsgd_pkg::MovieRowsDef
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_we,
    input  wire [0:0]          cfg_index,
    input  wire [15:0]         cfg_data,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire [1:0]          s_op,
    input  wire [15:0]         s_user_row,
    input  wire [14:0]         s_movie_row,
    input  wire [5:0]          s_feature,
    input  wire signed [31:0]  s_value,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_result,
    output logic               m_saturated
);
    logic [15:0] learn_rate_reg, reg_weight_reg;
    lfsgd_pkg::ctrl_t ctrl;
    lfsgd_pkg::stat_t stat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_rate_reg <= lfsgd_pkg::LearnRateRst;
            reg_weight_reg <= lfsgd_pkg::RegWeightRst;
        end else if (cfg_we) begin
            case (cfg_index)
                lfsgd_pkg::CfgLearnRate: learn_rate_reg <= cfg_data;
                lfsgd_pkg::CfgRegWeight: reg_weight_reg <= cfg_data;
                default: learn_rate_reg <= learn_rate_reg;
            endcase
        end
    end

    lfsgd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_op), .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .ctrl(ctrl)
    );

    lfsgd_datapath #(
        .NUM_FEATURES(NUM_FEATURES), .USER_ROWS(USER_ROWS), .MOVIE_ROWS(MOVIE_ROWS)
    ) u_dp (
        .aclk(aclk), .ctrl(ctrl), .stat(stat), .in_op(s_op),
        .in_user_row(s_user_row), .in_movie_row(s_movie_row),
        .in_feature(s_feature), .in_value(s_value),
        .learn_rate(learn_rate_reg), .reg_weight(reg_weight_reg),
        .res_value(m_result), .res_sat(m_saturated)
    );
endmodule
`default_nettype wire
